FILE: sv/icc_pkg.sv
// ----------------------------------------------------------------------------
// icc_pkg
// Shared constants, types and controller/datapath command structs for the
// isotonic confidence calibration fit.
// ----------------------------------------------------------------------------
package icc_pkg;

  localparam int MAX_SAMPLES     = 1024;
  localparam int MAX_KNOTS       = 16;
  localparam int MIN_FIT_SAMPLES = 10;
  localparam int SAMP_AW         = $clog2(MAX_SAMPLES);
  localparam int CNT_W           = 11;
  localparam int CONF_W          = 17;
  localparam int KEY_W           = CONF_W + 1;
  localparam int PROB_W          = 17;
  localparam int FRAC_W          = 16;
  localparam int DIV_STEPS       = CNT_W + FRAC_W;
  localparam int DCNT_W          = $clog2(DIV_STEPS);
  localparam int PROD_W          = 2 * CNT_W;

  localparam logic [CONF_W-1:0] ONE_Q16 = CONF_W'(65536);

  // One pooled block: highest confidence, successes, sample count
  typedef struct packed {
    logic [CONF_W-1:0] top;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  n;
  } blk_t;

  // Sample store write data select
  typedef enum logic [1:0] {
    SW_IN,
    SW_KEY,
    SW_RD
  } swsel_t;

  // Block stack write data select
  typedef enum logic [1:0] {
    BW_TOP,
    BW_MERGE,
    BW_RD
  } bwsel_t;

  typedef struct packed {
    logic               smem_we;
    logic [SAMP_AW-1:0] smem_waddr;
    swsel_t             smem_wsel;
    logic [SAMP_AW-1:0] smem_raddr;
    logic               key_ld;
    logic               bmem_we;
    logic [SAMP_AW-1:0] bmem_waddr;
    bwsel_t             bmem_wsel;
    logic [SAMP_AW-1:0] bmem_raddr;
    logic               top_push;
    logic               mul_ld;
    logic               top_merge;
    logic               prev_ld;
    logic               min_ld;
    logic               min_upd;
    logic               acc_ld;
    logic               div_init;
    logic               div_step;
    logic               out_ld;
    logic               out_short;
    logic               out_last;
    logic [CNT_W-1:0]   cnt;
    logic               ovf;
  } cmd_t;

  typedef struct packed {
    logic key_gt;
    logic viol;
    logic rd_lt_min;
  } sts_t;

  typedef struct packed {
    logic              model_valid;
    logic [CONF_W-1:0] knot_max_input;
    logic [PROB_W-1:0] knot_probability;
    logic [CNT_W-1:0]  knot_count;
    logic [CNT_W-1:0]  kept_samples;
    logic              sample_overflow;
    logic              last_knot;
  } res_t;

endpackage

FILE: sv/icc_if.sv
// ----------------------------------------------------------------------------
// icc_in_if / icc_out_if
// Valid/ready channels for samples in and knots out.
// ----------------------------------------------------------------------------
interface icc_in_if;
  import icc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CONF_W-1:0] confidence;
  logic              correct;
  logic              last_sample;
  modport source (output valid, confidence, correct, last_sample, input ready);
  modport sink   (input valid, confidence, correct, last_sample, output ready);
endinterface

interface icc_out_if;
  import icc_pkg::*;
  logic              valid;
  logic              ready;
  logic              model_valid;
  logic [CONF_W-1:0] knot_max_input;
  logic [PROB_W-1:0] knot_probability;
  logic [CNT_W-1:0]  knot_count;
  logic [CNT_W-1:0]  kept_samples;
  logic              sample_overflow;
  logic              last_knot;
  modport source (output valid, model_valid, knot_max_input, knot_probability,
                  knot_count, kept_samples, sample_overflow, last_knot,
                  input ready);
  modport sink   (input valid, model_valid, knot_max_input, knot_probability,
                  knot_count, kept_samples, sample_overflow, last_knot,
                  output ready);
endinterface

FILE: sv/isotonic_confidence_calibration_fit.sv
// ----------------------------------------------------------------------------
// isotonic_confidence_calibration_fit
// Isotonic (pool adjacent violators) calibration fit over a sample set.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one sample per transaction (confidence Q1.16, correct,
//   last_sample). Samples load one per cycle into a 1024-entry store; extra
//   samples are dropped and flagged. The transaction with last_sample closes
//   the set, and in_chan stays not ready until the last knot is taken.
//   Fewer than 10 samples: one result with model_valid low. Otherwise:
//   insertion sort, pool adjacent violators, knot reduction (merging while
//   above 16 blocks), then per knot the 27-step bit-serial divider. All
//   passes run on the single read/single write port of each memory.
//   out_chan holds each knot in an output register until taken; a stall on
//   out_chan simply holds the sequencer. Reset (synchronous, active low)
//   returns to loading with an empty set; memories are not cleared.
// ----------------------------------------------------------------------------
module isotonic_confidence_calibration_fit (
  input  logic       clk,
  input  logic       rst_n,
  icc_in_if.sink     in_chan,
  icc_out_if.source  out_chan
);
  import icc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  icc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_sample),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  icc_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_confidence (in_chan.confidence),
    .in_correct    (in_chan.correct),
    .sts           (sts),
    .res           (res)
  );

  assign out_chan.model_valid      = res.model_valid;
  assign out_chan.knot_max_input   = res.knot_max_input;
  assign out_chan.knot_probability = res.knot_probability;
  assign out_chan.knot_count       = res.knot_count;
  assign out_chan.kept_samples     = res.kept_samples;
  assign out_chan.sample_overflow  = res.sample_overflow;
  assign out_chan.last_knot        = res.last_knot;

endmodule

FILE: sv/icc_dp.sv
// ----------------------------------------------------------------------------
// icc_dp
// Datapath: sample store, block stack, rate comparator, knot-reduction
// minimum tracker, shift-subtract divider and the result register.
// ----------------------------------------------------------------------------
module icc_dp (
  input  logic                      clk,
  input  icc_pkg::cmd_t             cmd,
  input  logic [icc_pkg::CONF_W-1:0] in_confidence,
  input  logic                      in_correct,
  output icc_pkg::sts_t             sts,
  output icc_pkg::res_t             res
);
  import icc_pkg::*;

  logic [KEY_W-1:0] smem [MAX_SAMPLES];
  blk_t             bmem [MAX_SAMPLES];

  logic [KEY_W-1:0]  smem_rd_r;
  blk_t              bmem_rd_r;
  logic [KEY_W-1:0]  key_r;
  blk_t              top_r;
  blk_t              prev_r;
  blk_t              acc_r;
  blk_t              blk_r;
  logic [PROD_W-1:0] pa_r;
  logic [PROD_W-1:0] pb_r;
  logic [CNT_W-1:0]  min_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DIV_STEPS-1:0] dq_r;
  res_t              res_r;

  logic [CONF_W-1:0] conf_sat;
  logic [KEY_W-1:0]  smem_wdata;
  blk_t              bmem_wdata;
  blk_t              rd_merge;
  logic [CNT_W:0]    rem_sh;
  logic              qbit;

  // Saturate confidence above 1.0
  assign conf_sat = (in_confidence > ONE_Q16) ? ONE_Q16 : in_confidence;

  always_comb begin
    case (cmd.smem_wsel)
      SW_IN:   smem_wdata = {conf_sat, in_correct};
      SW_KEY:  smem_wdata = key_r;
      SW_RD:   smem_wdata = smem_rd_r;
      default: smem_wdata = key_r;
    endcase
  end

  // Block merged into its right neighbour
  assign rd_merge.top  = bmem_rd_r.top;
  assign rd_merge.hits = acc_r.hits + bmem_rd_r.hits;
  assign rd_merge.n    = acc_r.n + bmem_rd_r.n;

  always_comb begin
    case (cmd.bmem_wsel)
      BW_TOP:   bmem_wdata = top_r;
      BW_MERGE: bmem_wdata = rd_merge;
      BW_RD:    bmem_wdata = bmem_rd_r;
      default:  bmem_wdata = top_r;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (cmd.smem_we) begin
      smem[cmd.smem_waddr] <= smem_wdata;
    end
    smem_rd_r <= smem[cmd.smem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.bmem_we) begin
      bmem[cmd.bmem_waddr] <= bmem_wdata;
    end
    bmem_rd_r <= bmem[cmd.bmem_raddr];
  end

  // Divider step: one quotient bit per cycle
  assign rem_sh = {rem_r, dq_r[DIV_STEPS-1]};
  assign qbit   = (rem_sh >= {1'b0, blk_r.n});

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.key_ld) begin
      key_r <= smem_rd_r;
    end
    if (cmd.top_push) begin
      prev_r      <= top_r;
      top_r.top   <= smem_rd_r[KEY_W-1:1];
      top_r.hits  <= CNT_W'(smem_rd_r[0]);
      top_r.n     <= CNT_W'(1);
    end else if (cmd.top_merge) begin
      top_r.hits  <= prev_r.hits + top_r.hits;
      top_r.n     <= prev_r.n + top_r.n;
    end
    if (cmd.prev_ld) begin
      prev_r <= bmem_rd_r;
    end
    if (cmd.mul_ld) begin
      pa_r <= PROD_W'(prev_r.hits) * PROD_W'(top_r.n);
      pb_r <= PROD_W'(top_r.hits) * PROD_W'(prev_r.n);
    end
    if (cmd.min_ld || (cmd.min_upd && sts.rd_lt_min)) begin
      min_r <= bmem_rd_r.n;
    end
    if (cmd.acc_ld) begin
      acc_r <= bmem_rd_r;
    end
    if (cmd.div_init) begin
      blk_r <= bmem_rd_r;
      rem_r <= '0;
      dq_r  <= {bmem_rd_r.hits, FRAC_W'(0)};
    end else if (cmd.div_step) begin
      rem_r <= qbit ? CNT_W'(rem_sh - {1'b0, blk_r.n}) : rem_sh[CNT_W-1:0];
      dq_r  <= {dq_r[DIV_STEPS-2:0], qbit};
    end
    if (cmd.out_ld) begin
      res_r.kept_samples    <= cmd.cnt;
      res_r.sample_overflow <= cmd.ovf;
      res_r.last_knot       <= cmd.out_last;
      if (cmd.out_short) begin
        res_r.model_valid      <= 1'b0;
        res_r.knot_max_input   <= '0;
        res_r.knot_probability <= '0;
        res_r.knot_count       <= '0;
      end else begin
        res_r.model_valid      <= 1'b1;
        res_r.knot_max_input   <= blk_r.top;
        res_r.knot_probability <= dq_r[PROB_W-1:0];
        res_r.knot_count       <= blk_r.n;
      end
    end
  end

  // Status back to the controller
  assign sts.key_gt    = smem_rd_r > key_r;
  assign sts.viol      = pa_r > pb_r;
  assign sts.rd_lt_min = bmem_rd_r.n < min_r;

  assign res = res_r;

endmodule

FILE: sv/icc_ctrl.sv
// ----------------------------------------------------------------------------
// icc_ctrl
// Sequencer: load, insertion sort, pool adjacent violators, knot reduction
// and knot emission. Owns all loop indices and the channel handshakes.
// ----------------------------------------------------------------------------
module icc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  icc_pkg::sts_t  sts,
  output icc_pkg::cmd_t  cmd
);
  import icc_pkg::*;

  typedef enum logic [4:0] {
    S_LOAD,
    S_SHORT,
    S_SORT_RD,
    S_SORT_KEY,
    S_SORT_PRV,
    S_SORT_CMP,
    S_PAV_RD,
    S_PAV_PUSH,
    S_PAV_MUL,
    S_PAV_CMP,
    S_PAV_PREV,
    S_PAV_MORE,
    S_RED_CHK,
    S_RED_MIN0,
    S_RED_SCAN,
    S_RED_A,
    S_RED_B,
    S_RED_SH,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_DIV,
    S_EMIT_OUT,
    S_EMIT_WAIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  nb_r, nb_nxt;
  logic [CNT_W-1:0]  small_r, small_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              full;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  i_inc;
  logic [CNT_W-1:0]  nb_m1;
  logic [CNT_W-1:0]  j_inc;

  assign full    = (cnt_r == CNT_W'(MAX_SAMPLES));
  assign cnt_inc = full ? cnt_r : cnt_r + CNT_W'(1);
  assign i_inc   = i_r + CNT_W'(1);
  assign j_inc   = j_r + CNT_W'(1);
  assign nb_m1   = nb_r - CNT_W'(1);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    nb_nxt        = nb_r;
    small_nxt     = small_r;
    dcnt_nxt      = dcnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.smem_wsel = SW_KEY;
    cmd.bmem_wsel = BW_TOP;
    cmd.cnt       = cnt_r;
    cmd.ovf       = ovf_r;

    case (state_r)
      // Store samples, one transaction per cycle
      S_LOAD: begin
        if (in_valid) begin
          cmd.smem_we    = !full;
          cmd.smem_wsel  = SW_IN;
          cmd.smem_waddr = cnt_r[SAMP_AW-1:0];
          cnt_nxt        = cnt_inc;
          ovf_nxt        = ovf_r | full;
          if (in_last) begin
            if (cnt_inc < CNT_W'(MIN_FIT_SAMPLES)) begin
              state_nxt = S_SHORT;
            end else begin
              i_nxt     = CNT_W'(1);
              state_nxt = S_SORT_RD;
            end
          end
        end
      end
      S_SHORT: begin
        cmd.out_ld    = 1'b1;
        cmd.out_short = 1'b1;
        cmd.out_last  = 1'b1;
        last_nxt      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      // Insertion sort over the sample store
      S_SORT_RD: begin
        cmd.smem_raddr = i_r[SAMP_AW-1:0];
        state_nxt      = S_SORT_KEY;
      end
      S_SORT_KEY: begin
        cmd.key_ld = 1'b1;
        j_nxt      = i_r;
        state_nxt  = S_SORT_PRV;
      end
      S_SORT_PRV: begin
        if (j_r == '0) begin
          cmd.smem_we    = 1'b1;
          cmd.smem_wsel  = SW_KEY;
          cmd.smem_waddr = '0;
          i_nxt          = i_inc;
          state_nxt      = S_SORT_RD;
          if (i_inc == cnt_r) begin
            i_nxt     = '0;
            nb_nxt    = '0;
            state_nxt = S_PAV_RD;
          end
        end else begin
          cmd.smem_raddr = SAMP_AW'(j_r - CNT_W'(1));
          state_nxt      = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        cmd.smem_we    = 1'b1;
        cmd.smem_waddr = j_r[SAMP_AW-1:0];
        if (sts.key_gt) begin
          cmd.smem_wsel = SW_RD;
          j_nxt         = j_r - CNT_W'(1);
          state_nxt     = S_SORT_PRV;
        end else begin
          cmd.smem_wsel = SW_KEY;
          i_nxt         = i_inc;
          state_nxt     = S_SORT_RD;
          if (i_inc == cnt_r) begin
            i_nxt     = '0;
            nb_nxt    = '0;
            state_nxt = S_PAV_RD;
          end
        end
      end
      // Pool adjacent violators; top block lives in a register
      S_PAV_RD: begin
        cmd.smem_raddr = i_r[SAMP_AW-1:0];
        state_nxt      = S_PAV_PUSH;
      end
      S_PAV_PUSH: begin
        cmd.top_push   = 1'b1;
        cmd.bmem_we    = (nb_r != '0);
        cmd.bmem_wsel  = BW_TOP;
        cmd.bmem_waddr = nb_m1[SAMP_AW-1:0];
        nb_nxt         = nb_r + CNT_W'(1);
        i_nxt          = i_inc;
        state_nxt      = (nb_r != '0) ? S_PAV_MUL : S_PAV_MORE;
      end
      S_PAV_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_PAV_CMP;
      end
      S_PAV_CMP: begin
        state_nxt = S_PAV_MORE;
        if (sts.viol) begin
          cmd.top_merge = 1'b1;
          nb_nxt        = nb_m1;
          if (nb_r >= CNT_W'(3)) begin
            cmd.bmem_raddr = SAMP_AW'(nb_r - CNT_W'(3));
            state_nxt      = S_PAV_PREV;
          end
        end
      end
      S_PAV_PREV: begin
        cmd.prev_ld = 1'b1;
        state_nxt   = S_PAV_MUL;
      end
      S_PAV_MORE: begin
        if (i_r == cnt_r) begin
          cmd.bmem_we    = 1'b1;
          cmd.bmem_wsel  = BW_TOP;
          cmd.bmem_waddr = nb_m1[SAMP_AW-1:0];
          state_nxt      = S_RED_CHK;
        end else begin
          state_nxt = S_PAV_RD;
        end
      end
      // Knot reduction: find smallest block short of the last, merge right, close the gap
      S_RED_CHK: begin
        if (nb_r > CNT_W'(MAX_KNOTS)) begin
          cmd.bmem_raddr = '0;
          j_nxt          = CNT_W'(1);
          small_nxt      = '0;
          state_nxt      = S_RED_MIN0;
        end else begin
          j_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end
      end
      S_RED_MIN0: begin
        cmd.min_ld     = 1'b1;
        cmd.bmem_raddr = j_r[SAMP_AW-1:0];
        state_nxt      = S_RED_SCAN;
      end
      S_RED_SCAN: begin
        cmd.min_upd = 1'b1;
        if (sts.rd_lt_min) begin
          small_nxt = j_r;
        end
        j_nxt = j_inc;
        if (j_inc < nb_m1) begin
          cmd.bmem_raddr = j_inc[SAMP_AW-1:0];
        end else begin
          cmd.bmem_raddr = sts.rd_lt_min ? j_r[SAMP_AW-1:0] : small_r[SAMP_AW-1:0];
          state_nxt      = S_RED_A;
        end
      end
      S_RED_A: begin
        cmd.acc_ld     = 1'b1;
        cmd.bmem_raddr = SAMP_AW'(small_r + CNT_W'(1));
        state_nxt      = S_RED_B;
      end
      S_RED_B: begin
        cmd.bmem_we    = 1'b1;
        cmd.bmem_wsel  = BW_MERGE;
        cmd.bmem_waddr = small_r[SAMP_AW-1:0];
        j_nxt          = small_r + CNT_W'(1);
        if (small_r + CNT_W'(1) < nb_m1) begin
          cmd.bmem_raddr = SAMP_AW'(small_r + CNT_W'(2));
          state_nxt      = S_RED_SH;
        end else begin
          nb_nxt    = nb_m1;
          state_nxt = S_RED_CHK;
        end
      end
      S_RED_SH: begin
        cmd.bmem_we    = 1'b1;
        cmd.bmem_wsel  = BW_RD;
        cmd.bmem_waddr = j_r[SAMP_AW-1:0];
        if (j_inc < nb_m1) begin
          cmd.bmem_raddr = SAMP_AW'(j_r + CNT_W'(2));
          j_nxt          = j_inc;
        end else begin
          nb_nxt    = nb_m1;
          state_nxt = S_RED_CHK;
        end
      end
      // Emit one knot per block
      S_EMIT_RD: begin
        cmd.bmem_raddr = j_r[SAMP_AW-1:0];
        state_nxt      = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_EMIT_DIV;
      end
      S_EMIT_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EMIT_OUT;
        end
      end
      S_EMIT_OUT: begin
        cmd.out_ld    = 1'b1;
        cmd.out_last  = (j_inc == nb_r);
        last_nxt      = (j_inc == nb_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            nb_nxt    = '0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_inc;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      nb_r        <= '0;
      small_r     <= '0;
      dcnt_r      <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      nb_r        <= nb_nxt;
      small_r     <= small_nxt;
      dcnt_r      <= dcnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;

  // Checks
  a_valid_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_EMIT_WAIT)
    else $error("result valid outside the wait state");

  a_blocks_le_samples: assert property (@(posedge clk) disable iff (!rst_n)
    nb_r <= cnt_r)
    else $error("block count exceeds sample count");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond capacity");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && last_r |=> state_r == S_LOAD && cnt_r == '0)
    else $error("run did not close after final knot");

  a_emit_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT_OUT |-> nb_r <= CNT_W'(MAX_KNOTS))
    else $error("knot emitted before reduction finished");

endmodule
